[rtl/complex_arithmetic_unit_macros.svh]
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Short forms for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define CAU_AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation and status codes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_EXPONENT = 64;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int MODE_W       = 3;
  localparam int EXP_W        = 8;
  localparam int STAT_W       = 2;
  localparam int DIV_STEPS    = PROD_W + FRAC_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int POW_W        = $clog2(MAX_EXPONENT + 1);
  localparam int CNT_W        = 3;
  localparam int N_PROD_MUL   = 4;
  localparam int N_PROD_DIV   = 6;

  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POW = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;

  localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] FX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] FX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_MSAT,
    ST_DCHK,
    ST_DIV,
    ST_PWR,
    ST_FIN
  } cau_state_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DATA_W-1:0] q;
  } cau_div_res_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } cau_sat_t;

  function automatic cau_sat_t sat_acc(input logic signed [ACC_W-1:0] v);
    cau_sat_t r;
    logic [ACC_W-DATA_W:0] upper;
    upper = v[ACC_W-1:DATA_W-1];
    if ((&upper) || !(|upper)) begin
      r.ovf = 1'b0;
      r.val = v[DATA_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[ACC_W-1] ? FX_MIN : FX_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/cau_div.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Restoring divider, one quotient bit per cycle: num * 2^FRAC / den truncated
// toward zero, negated when neg is set, signed result saturated to the data width.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cau_pkg::PROD_W-1:0]  num,
  input  wire logic                        neg,
  input  wire logic [cau_pkg::PROD_W-1:0]  den,
  output cau_pkg::cau_div_res_t            res
);

  logic                             busy_r;
  logic                             fin_r;
  logic [cau_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [cau_pkg::DIV_STEPS-1:0]    dvd_r;
  logic [cau_pkg::PROD_W-1:0]       rem_r;
  logic [cau_pkg::DATA_W:0]         q_r;
  logic                             stk_r;
  logic                             neg_r;
  logic [cau_pkg::PROD_W-1:0]       den_r;
  cau_pkg::cau_div_res_t            res_r;

  logic [cau_pkg::PROD_W-1:0]       r_sh;
  logic                             ge;
  logic                             big;

  assign r_sh = {rem_r[cau_pkg::PROD_W-2:0], dvd_r[cau_pkg::DIV_STEPS-1]};
  assign ge   = (r_sh >= den_r);

  always_comb begin
    if (neg_r) begin
      big = stk_r | q_r[cau_pkg::DATA_W] |
            (q_r[cau_pkg::DATA_W-1] & (|q_r[cau_pkg::DATA_W-2:0]));
    end else begin
      big = stk_r | q_r[cau_pkg::DATA_W] | q_r[cau_pkg::DATA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= fin_r;
      fin_r      <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= {num, {cau_pkg::FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
        stk_r  <= 1'b0;
        neg_r  <= neg;
        den_r  <= den;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[cau_pkg::DIV_STEPS-2:0], 1'b0};
        rem_r <= ge ? (r_sh - den_r) : r_sh;
        q_r   <= {q_r[cau_pkg::DATA_W-1:0], ge};
        stk_r <= stk_r | q_r[cau_pkg::DATA_W];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == cau_pkg::DIV_CNT_W'(cau_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        res_r.ovf <= big;
        if (big) begin
          res_r.q <= neg_r ? cau_pkg::FX_MIN : cau_pkg::FX_MAX;
        end else begin
          res_r.q <= neg_r ? (-q_r[cau_pkg::DATA_W-1:0]) : q_r[cau_pkg::DATA_W-1:0];
        end
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit on Q16.16 parts. One item at a time: in_ready is high
// only while the sequencer idles, and a finished result waits in the output
// register so the next item can be taken meanwhile. Add and subtract go straight
// to the result; multiply runs four products through the shared 32x32 multiplier;
// divide runs six products through it, then two 80-step passes of the bit-serial
// divider; power runs one complex multiply per exponent step, at most 64 steps,
// after a divide for a negative exponent. The shared multiplier and the
// one-bit-per-cycle divider set the pace.
// ----------------------------------------------------------------------------
// Complex arithmetic unit, top level
// Sequencer around one multiplier, one accumulator adder and a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [cau_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [cau_pkg::DATA_W-1:0] in_a_re,
  input  wire logic signed [cau_pkg::DATA_W-1:0] in_a_im,
  input  wire logic signed [cau_pkg::DATA_W-1:0] in_b_re,
  input  wire logic signed [cau_pkg::DATA_W-1:0] in_b_im,
  input  wire logic signed [cau_pkg::EXP_W-1:0]  in_exponent,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic signed [cau_pkg::DATA_W-1:0] out_res_re,
  output      logic signed [cau_pkg::DATA_W-1:0] out_res_im,
  output      logic [cau_pkg::STAT_W-1:0]        out_status
);

  cau_pkg::cau_state_t state_r, state_nxt;

  logic [cau_pkg::MODE_W-1:0]        mode_r;
  logic signed [cau_pkg::DATA_W-1:0] x_re_r, x_im_r, y_re_r, y_im_r;
  logic signed [cau_pkg::ACC_W-1:0]  acc_re_r, acc_im_r, acc_d_r;
  logic signed [cau_pkg::PROD_W-1:0] prod_r;
  logic [cau_pkg::CNT_W-1:0]         cnt_r;
  logic                              is_div_r, inv_r, part_r, ovf_r, div0_r;
  logic [cau_pkg::POW_W-1:0]         pow_r;
  logic                              out_valid_r;
  logic signed [cau_pkg::DATA_W-1:0] out_re_r, out_im_r;
  logic [cau_pkg::STAT_W-1:0]        out_st_r;

  logic                              in_fire, out_load, div_start;
  logic [cau_pkg::CNT_W-1:0]         nprod, k;
  logic signed [cau_pkg::DATA_W-1:0] mul_a, mul_b;
  logic signed [cau_pkg::PROD_W-1:0] prod_c;
  logic signed [cau_pkg::ACC_W-1:0]  prod_ext, acc_sel, acc_upd, dv_src;
  logic                              acc_sub;
  logic [cau_pkg::PROD_W-1:0]        dv_mag;
  logic [cau_pkg::EXP_W-1:0]         ex_mag;
  logic [cau_pkg::POW_W-1:0]         ex_cnt;
  cau_pkg::cau_sat_t                 s_re, s_im, m_re, m_im;
  cau_pkg::cau_div_res_t             div_res;

  assign in_fire = in_valid & in_ready;
  assign nprod   = is_div_r ? cau_pkg::CNT_W'(cau_pkg::N_PROD_DIV)
                            : cau_pkg::CNT_W'(cau_pkg::N_PROD_MUL);
  assign k       = cnt_r - 1'b1;

  // shared multiplier operand select
  always_comb begin
    unique case (cnt_r)
      3'd0:    begin mul_a = x_re_r; mul_b = y_re_r; end
      3'd1:    begin mul_a = x_im_r; mul_b = y_im_r; end
      3'd2:    begin mul_a = x_im_r; mul_b = y_re_r; end
      3'd3:    begin mul_a = x_re_r; mul_b = y_im_r; end
      3'd4:    begin mul_a = y_re_r; mul_b = y_re_r; end
      3'd5:    begin mul_a = y_im_r; mul_b = y_im_r; end
      default: begin mul_a = x_re_r; mul_b = y_re_r; end
    endcase
  end
  assign prod_c = mul_a * mul_b;

  // accumulate: even term loads, odd term adds or subtracts
  assign prod_ext = {{(cau_pkg::ACC_W-cau_pkg::PROD_W){prod_r[cau_pkg::PROD_W-1]}}, prod_r};
  assign acc_sub  = ((k == 3'd1) && !is_div_r) || ((k == 3'd3) && is_div_r);
  always_comb begin
    unique case (k[2:1])
      2'd0:    acc_sel = acc_re_r;
      2'd1:    acc_sel = acc_im_r;
      default: acc_sel = acc_d_r;
    endcase
  end
  assign acc_upd = !k[0] ? prod_ext : (acc_sub ? acc_sel - prod_ext : acc_sel + prod_ext);

  // add/sub and product saturation
  always_comb begin
    if (in_mode == cau_pkg::MODE_SUB) begin
      s_re = cau_pkg::sat_acc(cau_pkg::ACC_W'(in_a_re) - cau_pkg::ACC_W'(in_b_re));
      s_im = cau_pkg::sat_acc(cau_pkg::ACC_W'(in_a_im) - cau_pkg::ACC_W'(in_b_im));
    end else begin
      s_re = cau_pkg::sat_acc(cau_pkg::ACC_W'(in_a_re) + cau_pkg::ACC_W'(in_b_re));
      s_im = cau_pkg::sat_acc(cau_pkg::ACC_W'(in_a_im) + cau_pkg::ACC_W'(in_b_im));
    end
  end
  assign m_re = cau_pkg::sat_acc(acc_re_r >>> cau_pkg::FRAC_BITS);
  assign m_im = cau_pkg::sat_acc(acc_im_r >>> cau_pkg::FRAC_BITS);

  assign ex_mag = in_exponent[cau_pkg::EXP_W-1] ? (-in_exponent) : in_exponent;
  assign ex_cnt = (32'(ex_mag) > 32'(cau_pkg::MAX_EXPONENT))
                  ? cau_pkg::POW_W'(cau_pkg::MAX_EXPONENT) : cau_pkg::POW_W'(ex_mag);

  assign dv_src = (state_r == cau_pkg::ST_DIV) ? acc_im_r : acc_re_r;
  assign dv_mag = dv_src[cau_pkg::ACC_W-1] ? cau_pkg::PROD_W'(-dv_src)
                                           : cau_pkg::PROD_W'(dv_src);

  cau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dv_mag),
    .neg   (dv_src[cau_pkg::ACC_W-1]),
    .den   (acc_d_r[cau_pkg::PROD_W-1:0]),
    .res   (div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cau_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == cau_pkg::MODE_MUL || in_mode == cau_pkg::MODE_DIV) begin
            state_nxt = cau_pkg::ST_MAC;
          end else if (in_mode == cau_pkg::MODE_POW) begin
            if (ex_cnt == '0) begin
              state_nxt = cau_pkg::ST_FIN;
            end else if (in_exponent[cau_pkg::EXP_W-1]) begin
              state_nxt = cau_pkg::ST_MAC;
            end else begin
              state_nxt = cau_pkg::ST_PWR;
            end
          end else begin
            state_nxt = cau_pkg::ST_FIN;
          end
        end
      end
      cau_pkg::ST_MAC: begin
        if (cnt_r == nprod) begin
          state_nxt = is_div_r ? cau_pkg::ST_DCHK : cau_pkg::ST_MSAT;
        end
      end
      cau_pkg::ST_MSAT: begin
        state_nxt = (mode_r == cau_pkg::MODE_POW) ? cau_pkg::ST_PWR : cau_pkg::ST_FIN;
      end
      cau_pkg::ST_DCHK: begin
        state_nxt = (acc_d_r == '0) ? cau_pkg::ST_FIN : cau_pkg::ST_DIV;
      end
      cau_pkg::ST_DIV: begin
        if (div_res.done && part_r) begin
          state_nxt = inv_r ? cau_pkg::ST_PWR : cau_pkg::ST_FIN;
        end
      end
      cau_pkg::ST_PWR: begin
        state_nxt = (pow_r == '0) ? cau_pkg::ST_FIN : cau_pkg::ST_MAC;
      end
      cau_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = cau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cau_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == cau_pkg::ST_IDLE);
    out_load  = (state_r == cau_pkg::ST_FIN) && (!out_valid_r || out_ready);
    div_start = ((state_r == cau_pkg::ST_DCHK) && (acc_d_r != '0)) ||
                ((state_r == cau_pkg::ST_DIV) && div_res.done && !part_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      cau_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_r   <= in_mode;
          x_re_r   <= in_a_re;
          x_im_r   <= in_a_im;
          y_re_r   <= in_b_re;
          y_im_r   <= in_b_im;
          ovf_r    <= 1'b0;
          div0_r   <= 1'b0;
          inv_r    <= 1'b0;
          cnt_r    <= '0;
          pow_r    <= ex_cnt;
          is_div_r <= (in_mode == cau_pkg::MODE_DIV) ||
                      ((in_mode == cau_pkg::MODE_POW) && in_exponent[cau_pkg::EXP_W-1]);
          if (in_mode == cau_pkg::MODE_ADD || in_mode == cau_pkg::MODE_SUB) begin
            x_re_r <= s_re.val;
            x_im_r <= s_im.val;
            ovf_r  <= s_re.ovf | s_im.ovf;
          end else if (in_mode == cau_pkg::MODE_POW) begin
            x_re_r <= cau_pkg::FX_ONE;
            x_im_r <= '0;
            y_re_r <= in_a_re;
            y_im_r <= in_a_im;
            inv_r  <= in_exponent[cau_pkg::EXP_W-1];
          end else if (in_mode != cau_pkg::MODE_MUL && in_mode != cau_pkg::MODE_DIV) begin
            x_re_r <= '0;
            x_im_r <= '0;
          end
        end
      end
      cau_pkg::ST_MAC: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r < nprod) begin
          prod_r <= prod_c;
        end
        if (cnt_r != '0) begin
          unique case (k[2:1])
            2'd0:    acc_re_r <= acc_upd;
            2'd1:    acc_im_r <= acc_upd;
            default: acc_d_r  <= acc_upd;
          endcase
        end
      end
      cau_pkg::ST_MSAT: begin
        x_re_r <= m_re.val;
        x_im_r <= m_im.val;
        ovf_r  <= ovf_r | m_re.ovf | m_im.ovf;
      end
      cau_pkg::ST_DCHK: begin
        part_r <= 1'b0;
        if (acc_d_r == '0) begin
          x_re_r <= cau_pkg::FX_MAX;
          x_im_r <= cau_pkg::FX_MAX;
          div0_r <= 1'b1;
        end
      end
      cau_pkg::ST_DIV: begin
        if (div_res.done) begin
          ovf_r <= ovf_r | div_res.ovf;
          part_r <= 1'b1;
          is_div_r <= 1'b0;
          if (!part_r) begin
            if (inv_r) y_re_r <= div_res.q;
            else       x_re_r <= div_res.q;
          end else begin
            if (inv_r) y_im_r <= div_res.q;
            else       x_im_r <= div_res.q;
          end
        end
      end
      cau_pkg::ST_PWR: begin
        if (pow_r != '0) begin
          pow_r    <= pow_r - 1'b1;
          cnt_r    <= '0;
          is_div_r <= 1'b0;
        end
      end
      cau_pkg::ST_FIN: begin
        if (out_load) begin
          out_re_r <= x_re_r;
          out_im_r <= x_im_r;
          if (div0_r) begin
            out_st_r <= cau_pkg::STAT_DIV0;
          end else if (ovf_r) begin
            out_st_r <= cau_pkg::STAT_OVF;
          end else begin
            out_st_r <= cau_pkg::STAT_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_re_r;
  assign out_res_im = out_im_r;
  assign out_status = out_st_r;

endmodule

`default_nettype wire

[rtl/cau_checker.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [cau_pkg::DATA_W-1:0] out_res_re,
  input wire logic signed [cau_pkg::DATA_W-1:0] out_res_im,
  input wire logic [cau_pkg::STAT_W-1:0]        out_status
);

  `CAU_AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_res_re) && $stable(out_res_im) && $stable(out_status))
  `CAU_AST_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CAU_AST_IMP(a_status_code, clk, rst_n, out_valid, out_status == cau_pkg::STAT_OK || out_status == cau_pkg::STAT_DIV0 || out_status == cau_pkg::STAT_OVF)
  `CAU_AST_IMP(a_div0_sat, clk, rst_n, out_valid && out_status == cau_pkg::STAT_DIV0, out_res_re == cau_pkg::FX_MAX && out_res_im == cau_pkg::FX_MAX)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire
